@@ rtl/core/line_rasterizer_defines.svh @@
// Assertion macros shared by the line rasterizer RTL.
// Uses clk and rst_n of the module that expands them; empty when SYNTH is set.
`ifndef LINE_RASTERIZER_DEFINES_SVH
`define LINE_RASTERIZER_DEFINES_SVH

`ifndef SYNTH

// Condition must hold at every clock edge out of reset.
`define LR_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define LR_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define LR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define LR_ASSERT_ALWAYS(lbl, cond, msg)
`define LR_ASSERT_IMPLY(lbl, ante, cons, msg)
`define LR_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ rtl/core/lr_pkg.sv @@
// Shared types and constants of the line rasterizer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package lr_pkg;

  localparam int COLOR_W  = 32;
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);
  localparam int MAX_PIX  = 3;
  localparam int PEND_W   = $clog2(MAX_PIX + 1);

  // Request codes carried on tuser
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  // Slots of the coordinate bundle passed from front to back
  localparam int C_CUR_X = 0;
  localparam int C_CUR_Y = 1;
  localparam int C_END_X = 2;
  localparam int C_END_Y = 3;
  localparam int C_MAJOR = 4;
  localparam int C_MINOR = 5;
  localparam int C_SLOTS = 6;

  typedef enum logic [5:0] {
    K_IDLE  = 6'b000001,
    K_POINT = 6'b000010,
    K_VERT  = 6'b000100,
    K_HORZ  = 6'b001000,
    K_XMAJ  = 6'b010000,
    K_YMAJ  = 6'b100000
  } kind_t;

  typedef struct packed {
    logic  is_start;
    kind_t kind;
    logic  minor_dir;  // 1 = decrement the minor coordinate
  } cmd_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/lr_front.sv @@
// Front end: decodes input beats and classifies start requests into a line kind.
// Depends on lr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lr_front #(
  parameter int COORD_BITS = 12,
  parameter int IN_W       = 48
) (
  input  wire logic                                  in_tuser,
  input  wire logic [IN_W-1:0]                       in_tdata,
  output lr_pkg::cmd_ctrl_t                          push_ctrl,
  output logic [lr_pkg::C_SLOTS*COORD_BITS-1:0]      push_coord
);

  logic [COORD_BITS-1:0] x1, y1, x2, y2;
  logic [COORD_BITS-1:0] dx, dy;
  logic [COORD_BITS-1:0] sx, sy, ex, ey;
  logic [COORD_BITS-1:0] cur_x, cur_y, end_x, end_y, major, minor;
  logic                  xmaj, swap;

  assign x1 = in_tdata[0*COORD_BITS +: COORD_BITS];
  assign y1 = in_tdata[1*COORD_BITS +: COORD_BITS];
  assign x2 = in_tdata[2*COORD_BITS +: COORD_BITS];
  assign y2 = in_tdata[3*COORD_BITS +: COORD_BITS];

  assign dx   = (x1 > x2) ? (x1 - x2) : (x2 - x1);
  assign dy   = (y1 > y2) ? (y1 - y2) : (y2 - y1);
  assign xmaj = (dx >= dy);
  assign swap = xmaj ? (x2 < x1) : (y2 < y1);

  // Diagonal lines run from the smaller major coordinate
  assign sx = swap ? x2 : x1;
  assign sy = swap ? y2 : y1;
  assign ex = swap ? x1 : x2;
  assign ey = swap ? y1 : y2;

  always_comb begin
    push_ctrl.is_start  = (in_tuser == lr_pkg::REQ_START);
    push_ctrl.kind      = lr_pkg::K_IDLE;
    push_ctrl.minor_dir = 1'b0;
    cur_x = x1;
    cur_y = y1;
    end_x = x1;
    end_y = y1;
    major = '0;
    minor = '0;
    if (dx == '0 && dy == '0) begin
      push_ctrl.kind = lr_pkg::K_POINT;
    end else if (dx == '0) begin
      push_ctrl.kind = lr_pkg::K_VERT;
      cur_y = (y1 < y2) ? y1 : y2;
      end_y = (y1 < y2) ? y2 : y1;
    end else if (dy == '0) begin
      push_ctrl.kind = lr_pkg::K_HORZ;
      cur_x = (x1 < x2) ? x1 : x2;
      end_x = (x1 < x2) ? x2 : x1;
    end else begin
      cur_x = sx;
      cur_y = sy;
      end_x = ex;
      end_y = ey;
      if (xmaj) begin
        push_ctrl.kind      = lr_pkg::K_XMAJ;
        major               = dx;
        minor               = dy;
        push_ctrl.minor_dir = (ey < sy);
      end else begin
        push_ctrl.kind      = lr_pkg::K_YMAJ;
        major               = dy;
        minor               = dx;
        push_ctrl.minor_dir = (ex < sx);
      end
    end
  end

  assign push_coord = {minor, major, end_y, end_x, cur_y, cur_x};

endmodule

`default_nettype wire

@@ rtl/core/lr_cmd_queue.sv @@
// Two-entry command queue between the classifying front and the drawing back.
// Depends on lr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lr_cmd_queue #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  push_valid,
  output logic                                       push_ready,
  input  wire lr_pkg::cmd_ctrl_t                     push_ctrl,
  input  wire logic [lr_pkg::C_SLOTS*COORD_BITS-1:0] push_coord,
  output logic                                       pop_valid,
  input  wire logic                                  pop_ready,
  output lr_pkg::cmd_ctrl_t                          pop_ctrl,
  output logic [lr_pkg::C_SLOTS*COORD_BITS-1:0]      pop_coord
);

  lr_pkg::cmd_ctrl_t                          ctrl_q_r  [lr_pkg::QDEPTH];
  logic [lr_pkg::C_SLOTS*COORD_BITS-1:0]      coord_q_r [lr_pkg::QDEPTH];
  logic [lr_pkg::QPTR_W-1:0]                  wr_ptr_r, rd_ptr_r;
  logic [lr_pkg::QCNT_W-1:0]                  count_r, count_nxt;
  logic                                       do_push, do_pop;

  localparam logic [lr_pkg::QCNT_W-1:0] FULL_CNT = lr_pkg::QCNT_W'(lr_pkg::QDEPTH);
  localparam logic [lr_pkg::QCNT_W-1:0] CNT_ONE  = lr_pkg::QCNT_W'(1);
  localparam logic [lr_pkg::QPTR_W-1:0] PTR_ONE  = lr_pkg::QPTR_W'(1);

  assign push_ready = (count_r != FULL_CNT);
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_ctrl   = ctrl_q_r[rd_ptr_r];
  assign pop_coord  = coord_q_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_ONE;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PTR_ONE;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ctrl_q_r[wr_ptr_r]  <= push_ctrl;
      coord_q_r[wr_ptr_r] <= push_coord;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/lr_back.sv @@
// Back end: holds the line state, runs one iteration per step command and
// streams the resulting pixels through an output register. Depends on lr_pkg.
`timescale 1ns / 1ps
`include "line_rasterizer_defines.svh"
`default_nettype none

module lr_back #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_wr_en,
  input  wire logic [lr_pkg::COLOR_W-1:0]            cfg_wr_data,
  input  wire logic                                  q_valid,
  output logic                                       q_ready,
  input  wire lr_pkg::cmd_ctrl_t                     q_ctrl,
  input  wire logic [lr_pkg::C_SLOTS*COORD_BITS-1:0] q_coord,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [COORD_BITS-1:0]                      out_x,
  output logic [COORD_BITS-1:0]                      out_y,
  output logic [lr_pkg::COLOR_W-1:0]                 out_color,
  output logic                                       out_last,
  output logic                                       out_done
);

  localparam int EW = COORD_BITS + 1;
  localparam logic [COORD_BITS-1:0]     C_ONE = COORD_BITS'(1);
  localparam logic [lr_pkg::PEND_W-1:0] P_ONE = lr_pkg::PEND_W'(1);
  localparam logic [lr_pkg::PEND_W-1:0] P_TWO = lr_pkg::PEND_W'(2);
  localparam logic [lr_pkg::PEND_W-1:0] P_THR = lr_pkg::PEND_W'(3);

  // Line state
  lr_pkg::kind_t           kind_r, kind_nxt;
  logic [COORD_BITS-1:0]   cur_x_r, cur_y_r, end_x_r, end_y_r, major_r, minor_r;
  logic [COORD_BITS-1:0]   cur_x_nxt, cur_y_nxt;
  logic [EW-1:0]           err_r, err_nxt;
  logic                    dir_r;
  logic [lr_pkg::COLOR_W-1:0] color_r;

  // Pixels of the current iteration, waiting for the output register
  logic [COORD_BITS-1:0]     pend_x_r [lr_pkg::MAX_PIX];
  logic [COORD_BITS-1:0]     pend_y_r [lr_pkg::MAX_PIX];
  logic                      pend_d_r [lr_pkg::MAX_PIX];
  logic [lr_pkg::PEND_W-1:0] pend_cnt_r;
  logic [COORD_BITS-1:0]     lst_x [lr_pkg::MAX_PIX];
  logic [COORD_BITS-1:0]     lst_y [lr_pkg::MAX_PIX];
  logic                      lst_d [lr_pkg::MAX_PIX];
  logic [lr_pkg::PEND_W-1:0] lst_cnt;

  // Output register
  logic                        out_valid_r, out_last_r, out_done_r;
  logic [COORD_BITS-1:0]       out_x_r, out_y_r;
  logic [lr_pkg::COLOR_W-1:0]  out_color_r;

  logic                  out_load, q_pop, xmaj, hit, at_end;
  logic [EW-1:0]         err_sum;
  logic [COORD_BITS-1:0] mv_x, mv_y;

  assign out_load = (pend_cnt_r != '0) && (!out_valid_r || out_ready);
  assign q_ready  = (pend_cnt_r == '0) || ((pend_cnt_r == P_ONE) && out_load);
  assign q_pop    = q_valid && q_ready;

  // Diagonal arithmetic
  assign xmaj    = (kind_r == lr_pkg::K_XMAJ);
  assign err_sum = err_r + {1'b0, minor_r};
  assign hit     = (err_sum >= {1'b0, major_r});
  assign mv_x    = dir_r ? (cur_x_r - C_ONE) : (cur_x_r + C_ONE);
  assign mv_y    = dir_r ? (cur_y_r - C_ONE) : (cur_y_r + C_ONE);
  assign at_end  = xmaj ? (cur_x_r == end_x_r) : (cur_y_r == end_y_r);

  always_comb begin
    kind_nxt  = kind_r;
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    err_nxt   = err_r;
    lst_cnt   = '0;
    for (int i = 0; i < lr_pkg::MAX_PIX; i++) begin
      lst_x[i] = cur_x_r;
      lst_y[i] = cur_y_r;
      lst_d[i] = 1'b0;
    end
    unique case (kind_r)
      lr_pkg::K_POINT: begin
        lst_cnt  = P_ONE;
        lst_d[0] = 1'b1;
        kind_nxt = lr_pkg::K_IDLE;
      end
      lr_pkg::K_VERT: begin
        lst_cnt = P_ONE;
        if (cur_y_r == end_y_r) begin
          lst_d[0] = 1'b1;
          kind_nxt = lr_pkg::K_IDLE;
        end else begin
          cur_y_nxt = cur_y_r + C_ONE;
        end
      end
      lr_pkg::K_HORZ: begin
        lst_cnt = P_ONE;
        if (cur_x_r == end_x_r) begin
          lst_d[0] = 1'b1;
          kind_nxt = lr_pkg::K_IDLE;
        end else begin
          cur_x_nxt = cur_x_r + C_ONE;
        end
      end
      lr_pkg::K_XMAJ, lr_pkg::K_YMAJ: begin
        lst_cnt = P_ONE;
        err_nxt = err_sum;
        if (hit) begin
          err_nxt = err_sum - {1'b0, major_r};
          if (xmaj) begin
            cur_y_nxt = mv_y;
          end else begin
            cur_x_nxt = mv_x;
          end
          lst_x[1] = xmaj ? cur_x_r : mv_x;
          lst_y[1] = xmaj ? mv_y : cur_y_r;
          lst_cnt  = P_TWO;
        end
        if (at_end) begin
          // Endpoint pixel closes the line
          if (hit) begin
            lst_x[2] = end_x_r;
            lst_y[2] = end_y_r;
            lst_d[2] = 1'b1;
            lst_cnt  = P_THR;
          end else begin
            lst_x[1] = end_x_r;
            lst_y[1] = end_y_r;
            lst_d[1] = 1'b1;
            lst_cnt  = P_TWO;
          end
          kind_nxt = lr_pkg::K_IDLE;
        end else if (xmaj) begin
          cur_x_nxt = cur_x_r + C_ONE;
        end else begin
          cur_y_nxt = cur_y_r + C_ONE;
        end
      end
      default: begin
        kind_nxt = lr_pkg::K_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r      <= lr_pkg::K_IDLE;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      end_x_r     <= '0;
      end_y_r     <= '0;
      major_r     <= '0;
      minor_r     <= '0;
      err_r       <= '0;
      dir_r       <= 1'b0;
      color_r     <= '0;
      pend_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        color_r <= cfg_wr_data;
      end
      if (q_pop) begin
        if (q_ctrl.is_start) begin
          kind_r     <= q_ctrl.kind;
          dir_r      <= q_ctrl.minor_dir;
          cur_x_r    <= q_coord[lr_pkg::C_CUR_X*COORD_BITS +: COORD_BITS];
          cur_y_r    <= q_coord[lr_pkg::C_CUR_Y*COORD_BITS +: COORD_BITS];
          end_x_r    <= q_coord[lr_pkg::C_END_X*COORD_BITS +: COORD_BITS];
          end_y_r    <= q_coord[lr_pkg::C_END_Y*COORD_BITS +: COORD_BITS];
          major_r    <= q_coord[lr_pkg::C_MAJOR*COORD_BITS +: COORD_BITS];
          minor_r    <= q_coord[lr_pkg::C_MINOR*COORD_BITS +: COORD_BITS];
          err_r      <= '0;
          pend_cnt_r <= '0;
        end else begin
          kind_r     <= kind_nxt;
          cur_x_r    <= cur_x_nxt;
          cur_y_r    <= cur_y_nxt;
          err_r      <= err_nxt;
          pend_cnt_r <= lst_cnt;
        end
      end else if (out_load) begin
        pend_cnt_r <= pend_cnt_r - P_ONE;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Pixel list and output payload
  always_ff @(posedge clk) begin
    if (q_pop && !q_ctrl.is_start) begin
      for (int i = 0; i < lr_pkg::MAX_PIX; i++) begin
        pend_x_r[i] <= lst_x[i];
        pend_y_r[i] <= lst_y[i];
        pend_d_r[i] <= lst_d[i];
      end
    end else if (out_load) begin
      for (int i = 0; i < lr_pkg::MAX_PIX - 1; i++) begin
        pend_x_r[i] <= pend_x_r[i+1];
        pend_y_r[i] <= pend_y_r[i+1];
        pend_d_r[i] <= pend_d_r[i+1];
      end
    end
    if (out_load) begin
      out_x_r     <= pend_x_r[0];
      out_y_r     <= pend_y_r[0];
      out_done_r  <= pend_d_r[0];
      out_last_r  <= (pend_cnt_r == P_ONE);
      out_color_r <= color_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_color = out_color_r;
  assign out_last  = out_last_r;
  assign out_done  = out_done_r;

  `LR_ASSERT_ALWAYS(a_pend_bound, pend_cnt_r <= P_THR, "pixel list overflow")
  `LR_ASSERT_IMPLY(a_err_below_major, (kind_r == lr_pkg::K_XMAJ) || (kind_r == lr_pkg::K_YMAJ), err_r < {1'b0, major_r}, "error accumulator reached major delta")
  `LR_ASSERT_IMPLY(a_done_is_last, out_valid_r && out_done_r, out_last_r, "line end not on last pixel of step")
  `LR_ASSERT_NEXT(a_idle_step_silent, q_pop && !q_ctrl.is_start && (kind_r == lr_pkg::K_IDLE), pend_cnt_r == '0, "idle step produced pixels")

endmodule

`default_nettype wire

@@ rtl/core/line_rasterizer.sv @@
// Top level of the line rasterizer: front classifier, command queue, drawing back.
// Depends on lr_pkg, lr_front, lr_cmd_queue and lr_back.
`timescale 1ns / 1ps
`default_nettype none

// Line rasterizer. Send a start beat (tuser = 0) carrying both endpoints, then
// one step beat (tuser = 1) per loop iteration; each step returns one to three
// pixel beats, the last of them flagged by out_tlast, and the final pixel of
// the line flagged by out_tuser. A step while no line is active returns
// nothing, and a new start abandons the current line. Input beats are taken
// every cycle while the two-entry command queue has room. The back end takes
// the next command only when its pending pixel list is empty or its last
// pixel is moving into the single pixel output register, which passes one
// beat per cycle unless out_tready holds it back. An accepted step beat
// passes the command queue, the pending pixel list and the output register.
// The color comes from cfg_wr_data; write it only while no line is being
// drawn.
module line_rasterizer #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // Configuration: line color
  input  wire logic                    cfg_wr_en,
  input  wire logic [31:0]             cfg_wr_data,
  // Request channel
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  input  wire logic                    in_tuser,   // req_type
  input  wire logic [((4*COORD_BITS+7)/8)*8-1:0] in_tdata,
                                       // start_x, start_y, finish_x, finish_y
  // Pixel channel
  output logic                         out_tvalid,
  input  wire logic                    out_tready,
  output logic                         out_tlast,  // step_last
  output logic                         out_tuser,  // line_done
  output logic [((2*COORD_BITS+32+7)/8)*8-1:0] out_tdata
                                       // pixel_x, pixel_y, pixel_color
);

  localparam int IN_W  = ((4*COORD_BITS+7)/8)*8;
  localparam int OUT_W = ((2*COORD_BITS+32+7)/8)*8;
  localparam int CW    = lr_pkg::C_SLOTS*COORD_BITS;

  lr_pkg::cmd_ctrl_t          push_ctrl, pop_ctrl;
  logic [CW-1:0]              push_coord, pop_coord;
  logic                       q_valid, q_ready;
  logic [COORD_BITS-1:0]      px_x, px_y;
  logic [lr_pkg::COLOR_W-1:0] px_color;

  // Classify start requests as they arrive
  lr_front #(
    .COORD_BITS (COORD_BITS),
    .IN_W       (IN_W)
  ) u_front (
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .push_ctrl  (push_ctrl),
    .push_coord (push_coord)
  );

  // Decouple acceptance from drawing
  lr_cmd_queue #(
    .COORD_BITS (COORD_BITS)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_tvalid),
    .push_ready (in_tready),
    .push_ctrl  (push_ctrl),
    .push_coord (push_coord),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_ctrl   (pop_ctrl),
    .pop_coord  (pop_coord)
  );

  // Hold line state, run iterations, drive pixel beats
  lr_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_ctrl      (pop_ctrl),
    .q_coord     (pop_coord),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_x       (px_x),
    .out_y       (px_y),
    .out_color   (px_color),
    .out_last    (out_tlast),
    .out_done    (out_tuser)
  );

  // Pack the pixel beat, x in the lowest bits, zero fill to whole bytes
  assign out_tdata = OUT_W'({px_color, px_y, px_x});

endmodule

`default_nettype wire

@@ bench/line_rasterizer_checker.sv @@
// Scoreboard for the line rasterizer: watches the color port and both streams,
// predicts every pixel beat from the accepted request beats and compares them.
// Depends on lr_pkg for the line kinds and request codes.
`timescale 1ns / 1ps

module line_rasterizer_checker #(
  parameter int COORD_BITS = 12,
  parameter int IN_W       = ((4*COORD_BITS+7)/8)*8,
  parameter int OUT_W      = ((2*COORD_BITS+32+7)/8)*8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [31:0]      cfg_wr_data,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic             in_tuser,
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic             out_tlast,
  input  logic             out_tuser,
  input  logic [OUT_W-1:0] out_tdata,
  output int               error_count,
  output int               pending_pixels
);

  localparam int CB = COORD_BITS;

  typedef struct packed {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic [31:0]   color;
    logic          last;
    logic          done;
  } pixel_t;

  // Shadow of the drawing state
  lr_pkg::kind_t kind;
  logic [CB-1:0] cur_x, cur_y, end_x, end_y;
  logic [CB-1:0] major_delta, minor_delta;
  logic [CB:0]   err_accum;
  logic          minor_down;
  logic [31:0]   line_color;

  pixel_t expected_pixels[$];
  int     pixel_index;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("pixel %0d: %s: got 0x%0h, expected 0x%0h", pixel_index, what, got, want);
    error_count++;
  endtask

  task automatic latch_line(input logic [CB-1:0] x1, y1, x2, y2);
    logic [CB-1:0] dx, dy, t;
    logic          swap;
    dx = (x1 > x2) ? x1 - x2 : x2 - x1;
    dy = (y1 > y2) ? y1 - y2 : y2 - y1;
    err_accum   = '0;
    major_delta = '0;
    minor_delta = '0;
    minor_down  = 1'b0;
    if (dx == 0 && dy == 0) begin
      kind  = lr_pkg::K_POINT;
      cur_x = x1; end_x = x1;
      cur_y = y1; end_y = y1;
    end else if (dx == 0) begin
      kind  = lr_pkg::K_VERT;
      cur_x = x1; end_x = x1;
      cur_y = (y1 < y2) ? y1 : y2;
      end_y = (y1 < y2) ? y2 : y1;
    end else if (dy == 0) begin
      kind  = lr_pkg::K_HORZ;
      cur_y = y1; end_y = y1;
      cur_x = (x1 < x2) ? x1 : x2;
      end_x = (x1 < x2) ? x2 : x1;
    end else begin
      // run along the major axis from its smaller end
      swap = (dx >= dy) ? (x2 < x1) : (y2 < y1);
      if (swap) begin
        t = x1; x1 = x2; x2 = t;
        t = y1; y1 = y2; y2 = t;
      end
      cur_x = x1; cur_y = y1; end_x = x2; end_y = y2;
      if (dx >= dy) begin
        kind        = lr_pkg::K_XMAJ;
        major_delta = dx;
        minor_delta = dy;
        minor_down  = (y2 < y1);
      end else begin
        kind        = lr_pkg::K_YMAJ;
        major_delta = dy;
        minor_delta = dx;
        minor_down  = (x2 < x1);
      end
    end
  endtask

  task automatic add_pixel(input logic [CB-1:0] x, y, input logic done);
    pixel_t p;
    p.x = x; p.y = y; p.color = line_color; p.last = 1'b0; p.done = done;
    expected_pixels.push_back(p);
  endtask

  task automatic draw_step();
    int     n_prior;
    logic   xmaj;
    pixel_t tail;
    n_prior = expected_pixels.size();
    xmaj    = (kind == lr_pkg::K_XMAJ);
    unique case (kind)
      lr_pkg::K_POINT: begin
        add_pixel(cur_x, cur_y, 1'b1);
        kind = lr_pkg::K_IDLE;
      end
      lr_pkg::K_VERT: begin
        if (cur_y == end_y) begin
          add_pixel(cur_x, cur_y, 1'b1);
          kind = lr_pkg::K_IDLE;
        end else begin
          add_pixel(cur_x, cur_y, 1'b0);
          cur_y = cur_y + 1'b1;
        end
      end
      lr_pkg::K_HORZ: begin
        if (cur_x == end_x) begin
          add_pixel(cur_x, cur_y, 1'b1);
          kind = lr_pkg::K_IDLE;
        end else begin
          add_pixel(cur_x, cur_y, 1'b0);
          cur_x = cur_x + 1'b1;
        end
      end
      lr_pkg::K_XMAJ, lr_pkg::K_YMAJ: begin
        add_pixel(cur_x, cur_y, 1'b0);
        err_accum = err_accum + minor_delta;
        if (err_accum >= major_delta) begin
          err_accum = err_accum - major_delta;
          if (xmaj) cur_y = minor_down ? cur_y - 1'b1 : cur_y + 1'b1;
          else      cur_x = minor_down ? cur_x - 1'b1 : cur_x + 1'b1;
          add_pixel(cur_x, cur_y, 1'b0);
        end
        if (xmaj ? (cur_x == end_x) : (cur_y == end_y)) begin
          add_pixel(end_x, end_y, 1'b1);
          kind = lr_pkg::K_IDLE;
        end else if (xmaj) begin
          cur_x = cur_x + 1'b1;
        end else begin
          cur_y = cur_y + 1'b1;
        end
      end
      default: kind = lr_pkg::K_IDLE;
    endcase
    // flag the final pixel of this step
    if (expected_pixels.size() > n_prior) begin
      tail = expected_pixels.pop_back();
      tail.last = 1'b1;
      expected_pixels.push_back(tail);
    end
  endtask

  task automatic check_pixel();
    pixel_t want;
    if (expected_pixels.size() == 0) begin
      report("pixel beat with none expected", 32'(out_tdata[0 +: CB]), 32'd0);
    end else begin
      want = expected_pixels.pop_front();
      if (out_tdata[0 +: CB] !== want.x)
        report("pixel_x", 32'(out_tdata[0 +: CB]), 32'(want.x));
      if (out_tdata[CB +: CB] !== want.y)
        report("pixel_y", 32'(out_tdata[CB +: CB]), 32'(want.y));
      if (out_tdata[2*CB +: 32] !== want.color)
        report("pixel_color", out_tdata[2*CB +: 32], want.color);
      if (out_tlast !== want.last)
        report("step_last", 32'(out_tlast), 32'(want.last));
      if (out_tuser !== want.done)
        report("line_done", 32'(out_tuser), 32'(want.done));
    end
    pixel_index++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      kind        = lr_pkg::K_IDLE;
      cur_x       = '0; cur_y = '0; end_x = '0; end_y = '0;
      major_delta = '0; minor_delta = '0; err_accum = '0;
      minor_down  = 1'b0;
      line_color  = '0;
      pixel_index = 0;
      error_count = 0;
      expected_pixels.delete();
    end else begin
      if (cfg_wr_en) line_color = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        if (in_tuser == lr_pkg::REQ_START)
          latch_line(in_tdata[0 +: CB], in_tdata[CB +: CB],
                     in_tdata[2*CB +: CB], in_tdata[3*CB +: CB]);
        else
          draw_step();
      end
      if (out_tvalid && out_tready) check_pixel();
    end
    pending_pixels <= expected_pixels.size();
  end

endmodule

@@ bench/line_rasterizer_test.sv @@
// Top of the line rasterizer bench: clock, reset, request and color stimulus,
// random backpressure and the verdict. Depends on lr_pkg, line_rasterizer and
// line_rasterizer_checker.
`timescale 1ns / 1ps

module line_rasterizer_test;

  localparam int CB          = 12;
  localparam int IN_W        = ((4*CB+7)/8)*8;
  localparam int OUT_W       = ((2*CB+32+7)/8)*8;
  localparam int QUIET_LIMIT = 2000;  // cycles without any accepted beat
  localparam logic [CB-1:0] CMAX = {CB{1'b1}};

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en = 1'b0;
  logic [31:0]      cfg_wr_data = '0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic             in_tuser = 1'b0;
  logic [IN_W-1:0]  in_tdata = '0;     // start_x, start_y, finish_x, finish_y
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic             out_tlast;
  logic             out_tuser;
  logic [OUT_W-1:0] out_tdata;         // pixel_x, pixel_y, pixel_color

  int error_count;
  int pending_pixels;
  int beats_sent  = 0;
  int sender_idle = 0;   // percent of cycles the request side holds off
  int recv_stall  = 0;   // percent of cycles the pixel side stalls
  int quiet_cycles = 0;

  line_rasterizer #(.COORD_BITS(CB)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  line_rasterizer_checker #(.COORD_BITS(CB)) pixel_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tuser      (in_tuser),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tlast     (out_tlast),
    .out_tuser     (out_tuser),
    .out_tdata     (out_tdata),
    .error_count   (error_count),
    .pending_pixels(pending_pixels)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Random backpressure on the pixel stream, rate set per phase
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall);
  end

  // Abort when the bench stops making progress: any beat on either side
  // restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Drive one request beat and hold it until accepted. Idle cycles drop valid
  // first; back-to-back beats keep valid high without a dip.
  task automatic send_beat(input logic req, input logic [IN_W-1:0] data);
    while ($urandom_range(99) < sender_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    beats_sent++;
  endtask

  // Step beats carry no coordinates; fill tdata with junk the block must ignore.
  function automatic logic [IN_W-1:0] junk_data();
    logic [IN_W-1:0] d;
    d = '0;
    d[31:0] = $urandom;
    d[IN_W-1:32] = (IN_W-32)'($urandom);
    return d;
  endfunction

  task automatic send_line(input logic [CB-1:0] x1, y1, x2, y2, input int steps);
    send_beat(lr_pkg::REQ_START, {y2, x2, y1, x1});
    repeat (steps) send_beat(lr_pkg::REQ_STEP, junk_data());
  endtask

  // Drop valid and hold until every predicted pixel has come back.
  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_pixels != 0) @(posedge clk);
  endtask

  // Change the color only with the block idle: drain, then let any start or
  // empty step still in the pipe clear before the write.
  task automatic recolor(input logic [31:0] color);
    hold_until_drained();
    repeat (8) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= color;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Mostly full-range coordinates, with the screen edges now and then.
  function automatic logic [CB-1:0] pick_coord();
    unique case ($urandom_range(7))
      0:       return '0;
      1:       return CMAX;
      default: return CB'($urandom_range(CMAX));
    endcase
  endfunction

  // A second endpoint close to the first, clamped to the screen.
  function automatic logic [CB-1:0] near(input logic [CB-1:0] base, input int span);
    int v;
    v = int'(base) + int'($urandom_range(2*span)) - span;
    if (v < 0) v = 0;
    if (v > CMAX) v = CMAX;
    return CB'(v);
  endfunction

  // One random line: usually short and drawn to the end, sometimes with
  // stray steps after it, sometimes abandoned early, and now and then a
  // long line with arbitrary endpoints that is cut off after a few steps.
  task automatic random_line();
    logic [CB-1:0] x1, y1, x2, y2;
    int span, dx, dy, full, steps, mode;
    if ($urandom_range(9) == 0) begin
      x1 = CB'($urandom_range(CMAX));
      y1 = CB'($urandom_range(CMAX));
      x2 = CB'($urandom_range(CMAX));
      y2 = CB'($urandom_range(CMAX));
      steps = $urandom_range(3);
    end else begin
      span = $urandom_range(1) ? 3 : 12;
      x1 = pick_coord();
      y1 = pick_coord();
      x2 = near(x1, span);
      y2 = near(y1, span);
      dx = (x1 > x2) ? x1 - x2 : x2 - x1;
      dy = (y1 > y2) ? y1 - y2 : y2 - y1;
      full = ((dx > dy) ? dx : dy) + 1;
      mode = $urandom_range(99);
      if (mode < 70)      steps = full;
      else if (mode < 85) steps = full + $urandom_range(1, 2);
      else                steps = $urandom_range(full - 1);
    end
    send_line(x1, y1, x2, y2, steps);
  endtask

  // Random phase with its own idling mix; somewhere in the middle the sender
  // pauses until the pixel stream has fully drained.
  task automatic run_phase(input int idle_pct, input int stall_pct, input int quota);
    int   first, pause_at;
    logic paused;
    sender_idle = idle_pct;
    recv_stall  = stall_pct;
    first    = beats_sent;
    pause_at = first + $urandom_range(quota/4, 3*quota/4);
    paused   = 1'b0;
    while (beats_sent - first < quota) begin
      if (!paused && beats_sent >= pause_at) begin
        hold_until_drained();
        paused = 1'b1;
      end
      random_line();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    recolor(32'hFFFF_FFFF);

    // Directed lines, no idling on either side.
    send_beat(lr_pkg::REQ_STEP, junk_data());     // step with no line active
    send_line(12'd5, 12'd5, 12'd5, 12'd5, 1);     // single point
    send_line(12'd100, CMAX, 12'd100, CMAX - 12'd2, 3);   // vertical, drawn upward
    send_line(CMAX, 12'd0, CMAX - 12'd2, 12'd0, 3);       // horizontal, reversed
    // equal deltas: the minor coordinate runs one past the end and wraps
    send_line(CMAX - 12'd2, CMAX - 12'd2, CMAX, CMAX, 3);
    send_line(12'd10, 12'd15, 12'd8, 12'd18, 4);  // y-major, x decreasing
    send_line(12'd20, CMAX, 12'd17, CMAX - 12'd1, 4);     // x-major, endpoints swapped

    run_phase(0, 0, 60);
    recolor(32'h0000_0000);
    run_phase(77, 0, 60);
    recolor($urandom);
    run_phase(0, 77, 60);
    recolor(32'h8000_0001);
    run_phase(28, 28, 60);

    hold_until_drained();
    repeat (20) @(posedge clk);
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/lr_pkg.sv
rtl/core/lr_front.sv
rtl/core/lr_cmd_queue.sv
rtl/core/lr_back.sv
rtl/core/line_rasterizer.sv
bench/line_rasterizer_checker.sv
bench/line_rasterizer_test.sv
